// ----- hw/rtl/sflp_pkg.sv -----
// Package: payload types, parser phases, error codes and start-line constants.
`default_nettype none

package sflp_pkg;

    localparam int LEN_W = 12;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       line_start;
        logic       buffer_end;
    } sflp_in_t;

    typedef struct packed {
        logic             is_request;
        logic [3:0]       method_code;
        logic [9:0]       status_code;
        logic [LEN_W-1:0] reason_length;
        logic [LEN_W-1:0] uri_length;
        logic [LEN_W-1:0] line_length;
        logic [3:0]       error_code;
    } sflp_out_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_HEAD     = 4'd1,
        PH_SVER     = 4'd2,
        PH_CODE     = 4'd3,
        PH_CODE_BAD = 4'd4,
        PH_REASON   = 4'd5,
        PH_RLF      = 4'd6,
        PH_URI      = 4'd7,
        PH_QVER     = 4'd8
    } phase_t;

    typedef enum logic [3:0] {
        ERR_OK          = 4'd0,
        ERR_CR_METHOD   = 4'd1,
        ERR_UNKNOWN     = 4'd2,
        ERR_VERSION     = 4'd3,
        ERR_NO_SP       = 4'd4,
        ERR_NON_DIGIT   = 4'd5,
        ERR_CODE_RANGE  = 4'd6,
        ERR_CR_NO_LF    = 4'd7,
        ERR_TRUNCATED   = 4'd8
    } err_t;

    // parser control state carried between the top level and the step logic
    typedef struct packed {
        phase_t     phase;
        logic [3:0] match_index;
        logic [9:0] code_acc;
        logic       request_flag;
        logic [3:0] method_result;
    } sflp_ctl_t;

    localparam int          METHOD_CNT = 9;
    localparam int          NAME_MAX   = 9;
    localparam logic [7:0]  CH_SP      = 8'h20;
    localparam logic [7:0]  CH_CR      = 8'h0d;
    localparam logic [7:0]  CH_LF      = 8'h0a;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_NINE    = 8'h39;
    localparam logic [9:0]  CODE_MIN   = 10'd100;
    localparam logic [9:0]  CODE_END   = 10'd700;

    // first character in the top byte
    localparam logic [63:0] STATUS_VER = "SIP/2.0 ";
    localparam logic [71:0] REQ_VER    = {"SIP/2.0", 8'h0d, 8'h0a};

    localparam logic [71:0] METHOD_NAME [METHOD_CNT] = '{
        {"ACK",      48'h0},
        {"BYE",      48'h0},
        {"CANCEL",   24'h0},
        {"INVITE",   24'h0},
        {"MESSAGE",  16'h0},
        {"NOTIFY",   24'h0},
        {"OPTIONS",  16'h0},
        {"REGISTER",  8'h0},
        "SUBSCRIBE"
    };

    localparam logic [3:0] METHOD_LEN [METHOD_CNT] = '{
        4'd3, 4'd3, 4'd6, 4'd6, 4'd7, 4'd6, 4'd7, 4'd8, 4'd9
    };

    function automatic logic [7:0] status_ver_byte(input logic [2:0] i);
        return STATUS_VER[8*(7-int'(i)) +: 8];
    endfunction

    function automatic logic [7:0] req_ver_byte(input logic [3:0] i);
        logic [7:0] b;
        b = 8'h00;
        if (i < 4'd9) begin
            b = REQ_VER[8*(8-int'(i)) +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] method_char(input int k, input int i);
        return METHOD_NAME[k][8*(8-i) +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sip_first_line_parser_core.sv -----
// Top level of the SIP start-line parser: input register, parser state, result register.
//
// Usage: message bytes enter on the s_ channel, one byte per transfer, with
// line_start on the first byte of each message and buffer_end on the last
// byte available. Each message yields exactly one result on the m_ channel:
// on success, at the first error, or at buffer end. Bytes after that result
// are dropped until the next line_start.
// Path: a byte accepted into the input register is parsed by the step logic
// from there; its result (if any) is loaded into the output register, which
// drives m_valid, when the byte advances.
// Throughput: one byte per cycle while no result is blocked; each byte needs
// one pass through the compare/count logic between the input register and the state registers.
// Stall: the output register holds a result while m_ready is low; the input
// register keeps taking bytes, and the parser keeps consuming bytes that
// produce no result. s_ready drops only when a byte that would produce a
// result waits behind an untaken result.
// Reset: aresetn (synchronous, active low) empties both registers and puts
// the parser in idle, waiting for a line_start byte.
`default_nettype none

module sip_first_line_parser_core #(
    parameter int LENGTH_LIMIT = 4095
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sflp_pkg::sflp_in_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sflp_pkg::sflp_out_t  m_item
);
    import sflp_pkg::*;

    localparam int CNT_W = $clog2(LENGTH_LIMIT + 1);

    logic             in_vld_reg;
    sflp_in_t         in_item_reg;
    sflp_ctl_t        ctl_reg;
    sflp_ctl_t        ctl_next;
    logic [CNT_W-1:0] reason_cnt_reg, reason_cnt_next;
    logic [CNT_W-1:0] uri_cnt_reg, uri_cnt_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [8:0][7:0]  method_bytes_reg;
    logic             mb_we;
    logic [3:0]       mb_idx;
    logic             emit;
    sflp_out_t        result;
    logic             out_vld_reg;
    sflp_out_t        out_reg;
    logic             advance;

    sflp_step #(
        .LENGTH_LIMIT (LENGTH_LIMIT),
        .CNT_W        (CNT_W)
    ) u_step (
        .item_i         (in_item_reg),
        .ctl_i          (ctl_reg),
        .reason_cnt_i   (reason_cnt_reg),
        .uri_cnt_i      (uri_cnt_reg),
        .byte_cnt_i     (byte_cnt_reg),
        .method_bytes_i (method_bytes_reg),
        .ctl_o          (ctl_next),
        .reason_cnt_o   (reason_cnt_next),
        .uri_cnt_o      (uri_cnt_next),
        .byte_cnt_o     (byte_cnt_next),
        .mb_we_o        (mb_we),
        .mb_idx_o       (mb_idx),
        .emit_o         (emit),
        .result_o       (result)
    );

    // a byte that produces no result never waits on the output side
    assign advance = in_vld_reg && (!emit || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            ctl_reg        <= '{phase: PH_IDLE, default: '0};
            reason_cnt_reg <= '0;
            uri_cnt_reg    <= '0;
            byte_cnt_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                ctl_reg        <= ctl_next;
                reason_cnt_reg <= reason_cnt_next;
                uri_cnt_reg    <= uri_cnt_next;
                byte_cnt_reg   <= byte_cnt_next;
            end
            if (advance && emit) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && emit) begin
            out_reg <= result;
        end
        if (advance && mb_we && mb_idx < 4'd9) begin
            method_bytes_reg[mb_idx] <= in_item_reg.msg_byte;
        end
    end

    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit |=> ctl_reg.phase == PH_IDLE)
        else $error("parser not idle after a result transfer");

    a_ready_low_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld_reg && emit && out_vld_reg && !m_ready)
        else $error("input stalled without a blocked result");

    a_status_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.is_request && m_item.error_code == ERR_OK
        |-> m_item.status_code >= CODE_MIN && m_item.status_code < CODE_END)
        else $error("accepted status line with code out of range");

    a_match_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.match_index <= 4'd10)
        else $error("match index out of bounds");

endmodule

`default_nettype wire

// ----- hw/rtl/sflp_step.sv -----
// Start-line parser next-state and result logic for one message byte.
`default_nettype none

module sflp_step #(
    parameter int LENGTH_LIMIT = 4095,
    parameter int CNT_W        = $clog2(LENGTH_LIMIT + 1)
) (
    input  sflp_pkg::sflp_in_t         item_i,
    input  sflp_pkg::sflp_ctl_t        ctl_i,
    input  logic [CNT_W-1:0]           reason_cnt_i,
    input  logic [CNT_W-1:0]           uri_cnt_i,
    input  logic [CNT_W-1:0]           byte_cnt_i,
    input  logic [8:0][7:0]            method_bytes_i,
    output sflp_pkg::sflp_ctl_t        ctl_o,
    output logic [CNT_W-1:0]           reason_cnt_o,
    output logic [CNT_W-1:0]           uri_cnt_o,
    output logic [CNT_W-1:0]           byte_cnt_o,
    output logic                       mb_we_o,
    output logic [3:0]                 mb_idx_o,
    output logic                       emit_o,
    output sflp_pkg::sflp_out_t        result_o
);
    import sflp_pkg::*;

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LENGTH_LIMIT);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < LIMIT) ? v + CNT_W'(1) : LIMIT;
    endfunction

    sflp_ctl_t        cur;
    sflp_ctl_t        nxt;
    logic [CNT_W-1:0] rc, uc, bc;
    logic [CNT_W-1:0] rn, un, bn;
    logic [7:0]       b;
    logic             meth_hit;
    logic [3:0]       meth_idx;
    logic             emit;
    logic             stop;
    logic             take_req;
    err_t             err;
    logic [13:0]      acc_mul;

    assign b = item_i.msg_byte;

    // a line-start byte restarts from the cleared state
    always_comb begin
        cur = ctl_i;
        rc  = reason_cnt_i;
        uc  = uri_cnt_i;
        bc  = byte_cnt_i;
        if (item_i.line_start) begin
            cur.phase         = PH_HEAD;
            cur.match_index   = '0;
            cur.code_acc      = '0;
            cur.request_flag  = 1'b0;
            cur.method_result = '0;
            rc = '0;
            uc = '0;
            bc = '0;
        end
    end

    // method token lookup over the stored bytes, length = match_index
    always_comb begin
        logic hit;
        meth_hit = 1'b0;
        meth_idx = '0;
        for (int k = METHOD_CNT - 1; k >= 0; k--) begin
            hit = (cur.match_index == METHOD_LEN[k]);
            for (int i = 0; i < NAME_MAX; i++) begin
                if (4'(i) < METHOD_LEN[k] && method_bytes_i[i] != method_char(k, i)) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                meth_hit = 1'b1;
                meth_idx = 4'(k);
            end
        end
    end

    assign acc_mul = {1'b0, cur.code_acc, 3'b000} + {3'b000, cur.code_acc, 1'b0}
                     + {10'd0, b[3:0]};

    always_comb begin
        nxt      = cur;
        rn       = rc;
        un       = uc;
        bn       = bc;
        emit     = 1'b0;
        stop     = 1'b0;
        err      = ERR_OK;
        mb_we_o  = 1'b0;
        take_req = 1'b0;
        if (cur.phase != PH_IDLE) begin
            bn = sat_inc(bc);
            unique case (cur.phase) inside
                PH_HEAD: begin
                    take_req = 1'b1;
                    if (!cur.request_flag && cur.match_index < 4'd3) begin
                        if (b == status_ver_byte(cur.match_index[2:0])) begin
                            mb_we_o         = 1'b1;
                            nxt.match_index = cur.match_index + 4'd1;
                            if (cur.match_index == 4'd2) begin
                                nxt.phase = PH_SVER;
                            end
                            take_req = 1'b0;
                        end else begin
                            nxt.request_flag = 1'b1;
                        end
                    end
                    if (take_req) begin
                        if (b == CH_SP) begin
                            if (!meth_hit) begin
                                emit = 1'b1;
                                err  = ERR_UNKNOWN;
                            end else begin
                                nxt.method_result = meth_idx;
                                nxt.phase         = PH_URI;
                            end
                        end else if (b == CH_CR) begin
                            emit = 1'b1;
                            err  = ERR_CR_METHOD;
                        end else begin
                            if (cur.match_index < 4'd9) begin
                                mb_we_o = 1'b1;
                            end
                            if (cur.match_index < 4'd10) begin
                                nxt.match_index = cur.match_index + 4'd1;
                            end
                        end
                    end
                end
                PH_SVER: begin
                    if (cur.match_index >= 4'd8
                        || b != status_ver_byte(cur.match_index[2:0])) begin
                        emit = 1'b1;
                        err  = ERR_VERSION;
                    end else if (cur.match_index == 4'd7) begin
                        nxt.phase       = PH_CODE;
                        nxt.match_index = '0;
                        nxt.code_acc    = '0;
                    end else begin
                        nxt.match_index = cur.match_index + 4'd1;
                    end
                end
                PH_CODE, PH_CODE_BAD: begin
                    if (cur.match_index < 4'd3) begin
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            nxt.code_acc = acc_mul[9:0];
                        end else begin
                            nxt.phase = PH_CODE_BAD;
                        end
                        nxt.match_index = cur.match_index + 4'd1;
                    end else if (b != CH_SP) begin
                        emit = 1'b1;
                        err  = ERR_NO_SP;
                    end else if (cur.phase == PH_CODE_BAD) begin
                        emit = 1'b1;
                        err  = ERR_NON_DIGIT;
                    end else if (cur.code_acc < CODE_MIN || cur.code_acc >= CODE_END) begin
                        emit = 1'b1;
                        err  = ERR_CODE_RANGE;
                    end else begin
                        nxt.phase = PH_REASON;
                    end
                end
                PH_REASON: begin
                    if (b == CH_CR) begin
                        nxt.phase = PH_RLF;
                    end else begin
                        rn = sat_inc(rc);
                    end
                end
                PH_RLF: begin
                    emit = 1'b1;
                    err  = (b == CH_LF) ? ERR_OK : ERR_CR_NO_LF;
                end
                PH_URI: begin
                    if (b == CH_SP) begin
                        nxt.phase       = PH_QVER;
                        nxt.match_index = '0;
                    end else if (b == CH_CR) begin
                        emit = 1'b1;
                        err  = ERR_VERSION;
                    end else begin
                        un = sat_inc(uc);
                    end
                end
                PH_QVER: begin
                    if (cur.match_index >= 4'd9 || b != req_ver_byte(cur.match_index)) begin
                        emit = 1'b1;
                        err  = ERR_VERSION;
                    end else begin
                        nxt.match_index = cur.match_index + 4'd1;
                        if (cur.match_index == 4'd8) begin
                            emit = 1'b1;
                            err  = ERR_OK;
                        end
                    end
                end
                default: begin
                    nxt.phase = PH_IDLE;
                    stop      = 1'b1;
                end
            endcase
            // end of buffer: a status line inside its reason phrase is complete, any other line is truncated
            if (!emit && !stop && item_i.buffer_end) begin
                emit = 1'b1;
                err  = (nxt.phase == PH_REASON) ? ERR_OK : ERR_TRUNCATED;
            end
        end
        if (emit) begin
            nxt.phase = PH_IDLE;
        end
    end

    assign ctl_o        = nxt;
    assign reason_cnt_o = rn;
    assign uri_cnt_o    = un;
    assign byte_cnt_o   = bn;
    assign mb_idx_o     = cur.match_index;
    assign emit_o       = emit;

    always_comb begin
        result_o.is_request    = nxt.request_flag;
        result_o.method_code   = nxt.request_flag ? nxt.method_result : 4'd0;
        result_o.status_code   = (err == ERR_OK && !nxt.request_flag) ? nxt.code_acc : 10'd0;
        result_o.reason_length = LEN_W'(rn);
        result_o.uri_length    = LEN_W'(un);
        result_o.line_length   = LEN_W'(bn);
        result_o.error_code    = err;
    end

endmodule

`default_nettype wire
